### rtl/lhsa_pkg.sv
// Package for the lock hold stack auditor: operation codes, controller
// state type and the command bundle from controller to datapath.
// No dependencies.
`timescale 1ns / 1ps

package lhsa_pkg;

    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_ACQUIRE     = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE     = 3'd1;
    localparam logic [OP_W-1:0] OP_CONTENDED   = 3'd2;
    localparam logic [OP_W-1:0] OP_UNCONTENDED = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;

    localparam int LOCK_ID_W = 64;
    localparam int OUT_CNT_W = 32;
    localparam int OUT_DEPTH_W = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;     // capture the input transfer
        logic compare;  // build the match vector over the stack
        logic exec;     // apply the operation and load the result register
    } t_cmd;

endpackage

### rtl/lhsa_ctrl.sv
// Controller for the lock hold stack auditor: sequencing of capture,
// compare and execute, plus input ready and result valid.
// Depends on lhsa_pkg.
`timescale 1ns / 1ps

module lhsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lhsa_pkg::t_cmd o_cmd
);
    import lhsa_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   exec_go;
    logic   in_acc;

    // execute only when the result register is free or being drained
    assign exec_go = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE) || exec_go;
    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (exec_go) n_state = in_acc ? ST_CMP : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load    = in_acc;
        o_cmd.compare = (r_state == ST_CMP);
        o_cmd.exec    = exec_go;
        if (exec_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/lhsa_dp.sv
// Datapath for the lock hold stack auditor: hold stack registers, parallel
// id compare, shift on release, saturating counters and result register.
// Depends on lhsa_pkg.
`timescale 1ns / 1ps

module lhsa_dp #(
    parameter int STACK_DEPTH   = 32,
    parameter int COUNTER_WIDTH = 32,
    parameter int ID_WIDTH      = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lhsa_pkg::t_cmd                      i_cmd,
    input  logic [lhsa_pkg::OP_W-1:0]           i_op,
    input  logic [lhsa_pkg::LOCK_ID_W-1:0]      i_lock_id,
    output logic [lhsa_pkg::OUT_CNT_W-1:0]      o_acquisition_count,
    output logic [lhsa_pkg::OUT_CNT_W-1:0]      o_contention_count,
    output logic [lhsa_pkg::OUT_CNT_W-1:0]      o_nested_count,
    output logic [lhsa_pkg::OUT_CNT_W-1:0]      o_reentrant_count,
    output logic [lhsa_pkg::OUT_CNT_W-1:0]      o_uncontended_count,
    output logic [lhsa_pkg::OUT_DEPTH_W-1:0]    o_peak_depth,
    output logic [lhsa_pkg::OUT_DEPTH_W-1:0]    o_current_depth,
    output logic                                o_was_reentrant,
    output logic                                o_release_matched
);
    import lhsa_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = COUNTER_WIDTH;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    logic [OP_W-1:0]        r_op;
    logic [ID_WIDTH-1:0]    r_id;
    logic [ID_WIDTH-1:0]    r_stack [STACK_DEPTH];
    logic [ID_WIDTH-1:0]    n_stack [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_match;
    logic [DW-1:0]          r_depth, n_depth;
    logic [DW-1:0]          r_deepest, n_deepest;
    logic [CW-1:0]          r_acq, n_acq;
    logic [CW-1:0]          r_cont, n_cont;
    logic [CW-1:0]          r_nest, n_nest;
    logic [CW-1:0]          r_reent, n_reent;
    logic [CW-1:0]          r_uncont, n_uncont;
    logic                   n_was_reent, n_matched;
    logic                   hit;
    logic [IW-1:0]          top_idx;
    logic [DW-1:0]          push_depth;

    logic [OUT_CNT_W-1:0]   r_out_acq, r_out_cont, r_out_nest, r_out_reent, r_out_uncont;
    logic [OUT_DEPTH_W-1:0] r_out_peak, r_out_cur;
    logic                   r_out_reent_flag, r_out_matched;

    // zero-extend then take the low bits, whichever side is wider
    logic [CW+OUT_CNT_W-1:0]  x_acq, x_cont, x_nest, x_reent, x_uncont;
    logic [DW+OUT_DEPTH_W-1:0] x_peak, x_cur;

    assign hit = |r_match;

    // topmost live match wins
    always_comb begin
        top_idx = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (r_match[i]) top_idx = IW'(i);
        end
    end

    always_comb begin
        n_stack     = r_stack;
        n_depth     = r_depth;
        n_deepest   = r_deepest;
        n_acq       = r_acq;
        n_cont      = r_cont;
        n_nest      = r_nest;
        n_reent     = r_reent;
        n_uncont    = r_uncont;
        n_was_reent = 1'b0;
        n_matched   = 1'b0;
        push_depth  = r_depth;
        case (r_op)
            OP_ACQUIRE: begin
                if (hit) begin
                    n_reent     = sat_inc(r_reent);
                    n_was_reent = 1'b1;
                end else begin
                    if (r_depth != '0) n_nest = sat_inc(r_nest);
                    if (int'(r_depth) < STACK_DEPTH) begin
                        for (int i = 0; i < STACK_DEPTH; i++) begin
                            if (r_depth == DW'(i)) n_stack[i] = r_id;
                        end
                        push_depth = r_depth + 1'b1;
                    end
                    n_depth = push_depth;
                    if (push_depth > r_deepest) n_deepest = push_depth;
                    n_acq = sat_inc(r_acq);
                end
            end
            OP_RELEASE: begin
                if (hit) begin
                    // close the gap: entries above the match move down one
                    for (int j = 0; j < STACK_DEPTH - 1; j++) begin
                        if (j >= int'(top_idx)) n_stack[j] = r_stack[j+1];
                    end
                    n_depth   = r_depth - 1'b1;
                    n_matched = 1'b1;
                end
            end
            OP_CONTENDED: begin
                n_cont = sat_inc(r_cont);
            end
            OP_UNCONTENDED: begin
                n_uncont = sat_inc(r_uncont);
            end
            OP_CLEAR: begin
                n_acq     = '0;
                n_cont    = '0;
                n_nest    = '0;
                n_reent   = '0;
                n_uncont  = '0;
                n_deepest = '0;
            end
            default: begin
            end
        endcase
    end

    assign x_acq    = {{OUT_CNT_W{1'b0}}, n_acq};
    assign x_cont   = {{OUT_CNT_W{1'b0}}, n_cont};
    assign x_nest   = {{OUT_CNT_W{1'b0}}, n_nest};
    assign x_reent  = {{OUT_CNT_W{1'b0}}, n_reent};
    assign x_uncont = {{OUT_CNT_W{1'b0}}, n_uncont};
    assign x_peak   = {{OUT_DEPTH_W{1'b0}}, n_deepest};
    assign x_cur    = {{OUT_DEPTH_W{1'b0}}, n_depth};

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_id <= i_lock_id[ID_WIDTH-1:0];
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < STACK_DEPTH; i++) begin
                r_match[i] <= (r_stack[i] == r_id) && (DW'(i) < r_depth);
            end
        end
        if (i_cmd.exec) begin
            r_stack          <= n_stack;
            r_out_acq        <= x_acq[OUT_CNT_W-1:0];
            r_out_cont       <= x_cont[OUT_CNT_W-1:0];
            r_out_nest       <= x_nest[OUT_CNT_W-1:0];
            r_out_reent      <= x_reent[OUT_CNT_W-1:0];
            r_out_uncont     <= x_uncont[OUT_CNT_W-1:0];
            r_out_peak       <= x_peak[OUT_DEPTH_W-1:0];
            r_out_cur        <= x_cur[OUT_DEPTH_W-1:0];
            r_out_reent_flag <= n_was_reent;
            r_out_matched    <= n_matched;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_deepest <= '0;
            r_acq     <= '0;
            r_cont    <= '0;
            r_nest    <= '0;
            r_reent   <= '0;
            r_uncont  <= '0;
        end else if (i_cmd.exec) begin
            r_depth   <= n_depth;
            r_deepest <= n_deepest;
            r_acq     <= n_acq;
            r_cont    <= n_cont;
            r_nest    <= n_nest;
            r_reent   <= n_reent;
            r_uncont  <= n_uncont;
        end
    end

    assign o_acquisition_count = r_out_acq;
    assign o_contention_count  = r_out_cont;
    assign o_nested_count      = r_out_nest;
    assign o_reentrant_count   = r_out_reent;
    assign o_uncontended_count = r_out_uncont;
    assign o_peak_depth        = r_out_peak;
    assign o_current_depth     = r_out_cur;
    assign o_was_reentrant     = r_out_reent_flag;
    assign o_release_matched   = r_out_matched;

endmodule

### rtl/lock_hold_stack_auditor_top.sv
// Lock hold stack auditor, top level. After the input transfer the
// parallel id compare over the stack is registered, then the operation
// is applied and the result register loaded, raising o_m_tvalid. A new
// input is taken only while idle or as the current item executes; a
// stalled result holds the execute step. Reset clears the stack depth,
// counters and peak depth at once; the stack entries are not cleared.
`timescale 1ns / 1ps

module lock_hold_stack_auditor_top #(
    parameter int STACK_DEPTH   = 32,
    parameter int COUNTER_WIDTH = 32,
    parameter int ID_WIDTH      = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [lhsa_pkg::LOCK_ID_W-1:0]    i_s_tdata,  // [63:0] lock_id
    input  logic [lhsa_pkg::OP_W-1:0]         i_s_tuser,  // [2:0] operation
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] acquisition_count, [63:32] contention_count, [95:64] nested_count,
    // [127:96] reentrant_count, [159:128] uncontended_count, [165:160] peak_depth,
    // [171:166] current_depth, [172] was_reentrant, [173] release_matched,
    // [175:174] zero
    output logic [175:0]                      o_m_tdata
);
    import lhsa_pkg::*;

    t_cmd                   cmd;
    logic [OUT_CNT_W-1:0]   acq, cont, nest, reent, uncont;
    logic [OUT_DEPTH_W-1:0] peak, cur;
    logic                   was_reent, matched;

    lhsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_cmd       (cmd)
    );

    lhsa_dp #(
        .STACK_DEPTH   (STACK_DEPTH),
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .ID_WIDTH      (ID_WIDTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_op                (i_s_tuser),
        .i_lock_id           (i_s_tdata),
        .o_acquisition_count (acq),
        .o_contention_count  (cont),
        .o_nested_count      (nest),
        .o_reentrant_count   (reent),
        .o_uncontended_count (uncont),
        .o_peak_depth        (peak),
        .o_current_depth     (cur),
        .o_was_reentrant     (was_reent),
        .o_release_matched   (matched)
    );

    assign o_m_tdata = {2'b00, matched, was_reent, cur, peak, uncont, reent, nest, cont, acq};

endmodule

### dv/lock_hold_stack_auditor_checker.sv
// Scoreboard for the lock hold stack auditor: watches both stream channels,
// keeps its own hold stack and counters, and compares every result transfer.
// Depends on lhsa_pkg for the operation codes and channel widths.
`timescale 1ns / 1ps

module lock_hold_stack_auditor_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [lhsa_pkg::LOCK_ID_W-1:0] i_s_tdata,  // [63:0] lock_id
    input  logic [lhsa_pkg::OP_W-1:0]      i_s_tuser,  // [2:0] operation
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [31:0] acquisition_count, [63:32] contention_count, [95:64] nested_count,
    // [127:96] reentrant_count, [159:128] uncontended_count, [165:160] peak_depth,
    // [171:166] current_depth, [172] was_reentrant, [173] release_matched
    input  logic [175:0]                   i_m_tdata,
    output int                             o_fail_count,
    output int                             o_pending
);

    import lhsa_pkg::*;

    localparam int HOLD_SLOTS = 32;

    // Laid out MSB first so it overlays the result tdata directly
    typedef struct packed {
        logic [1:0]  pad;
        logic        release_matched;
        logic        was_reentrant;
        logic [5:0]  current_depth;
        logic [5:0]  peak_depth;
        logic [31:0] uncontended_count;
        logic [31:0] reentrant_count;
        logic [31:0] nested_count;
        logic [31:0] contention_count;
        logic [31:0] acquisition_count;
    } t_tally;

    logic [LOCK_ID_W-1:0] held_locks [HOLD_SLOTS];
    int unsigned          held_depth;
    int unsigned          peak_seen;
    logic [31:0]          acq_cnt;
    logic [31:0]          cont_cnt;
    logic [31:0]          nest_cnt;
    logic [31:0]          reent_cnt;
    logic [31:0]          uncont_cnt;

    t_tally expected_tallies [$];
    t_tally oldest_tally;
    int     mismatches = 0;
    int     results_seen = 0;

    assign o_fail_count = mismatches;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic t_tally apply_lock_event(input logic [OP_W-1:0] op,
                                                input logic [LOCK_ID_W-1:0] id);
        t_tally      t;
        logic        hit;
        int unsigned i;
        int unsigned j;
        t = '0;
        hit = 1'b0;
        case (op)
            OP_ACQUIRE: begin
                for (i = 0; i < held_depth; i++)
                    if (held_locks[i] == id)
                        hit = 1'b1;
                if (hit) begin
                    reent_cnt = bump(reent_cnt);
                    t.was_reentrant = 1'b1;
                end else begin
                    if (held_depth > 0)
                        nest_cnt = bump(nest_cnt);
                    // full stack: still counted, id dropped
                    if (held_depth < HOLD_SLOTS) begin
                        held_locks[held_depth] = id;
                        held_depth++;
                    end
                    if (held_depth > peak_seen)
                        peak_seen = held_depth;
                    acq_cnt = bump(acq_cnt);
                end
            end
            OP_RELEASE: begin
                // topmost match is removed, entries above it slide down
                for (i = held_depth; i > 0 && !hit; i--) begin
                    if (held_locks[i-1] == id) begin
                        hit = 1'b1;
                        for (j = i - 1; j + 1 < held_depth; j++)
                            held_locks[j] = held_locks[j+1];
                    end
                end
                if (hit) begin
                    held_depth--;
                    t.release_matched = 1'b1;
                end
            end
            OP_CONTENDED:   cont_cnt = bump(cont_cnt);
            OP_UNCONTENDED: uncont_cnt = bump(uncont_cnt);
            OP_CLEAR: begin
                acq_cnt    = '0;
                cont_cnt   = '0;
                nest_cnt   = '0;
                reent_cnt  = '0;
                uncont_cnt = '0;
                peak_seen  = 0;
            end
            default: ;
        endcase
        t.acquisition_count = acq_cnt;
        t.contention_count  = cont_cnt;
        t.nested_count      = nest_cnt;
        t.reentrant_count   = reent_cnt;
        t.uncontended_count = uncont_cnt;
        t.peak_depth        = 6'(peak_seen);
        t.current_depth     = 6'(held_depth);
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic compare_tally(input t_tally got, input t_tally want);
        if (got.acquisition_count !== want.acquisition_count)
            report_mismatch("acquisition_count", 64'(got.acquisition_count),
                            64'(want.acquisition_count));
        if (got.contention_count !== want.contention_count)
            report_mismatch("contention_count", 64'(got.contention_count),
                            64'(want.contention_count));
        if (got.nested_count !== want.nested_count)
            report_mismatch("nested_count", 64'(got.nested_count),
                            64'(want.nested_count));
        if (got.reentrant_count !== want.reentrant_count)
            report_mismatch("reentrant_count", 64'(got.reentrant_count),
                            64'(want.reentrant_count));
        if (got.uncontended_count !== want.uncontended_count)
            report_mismatch("uncontended_count", 64'(got.uncontended_count),
                            64'(want.uncontended_count));
        if (got.peak_depth !== want.peak_depth)
            report_mismatch("peak_depth", 64'(got.peak_depth),
                            64'(want.peak_depth));
        if (got.current_depth !== want.current_depth)
            report_mismatch("current_depth", 64'(got.current_depth),
                            64'(want.current_depth));
        if (got.was_reentrant !== want.was_reentrant)
            report_mismatch("was_reentrant", 64'(got.was_reentrant),
                            64'(want.was_reentrant));
        if (got.release_matched !== want.release_matched)
            report_mismatch("release_matched", 64'(got.release_matched),
                            64'(want.release_matched));
        if (got.pad !== want.pad)
            report_mismatch("pad bits", 64'(got.pad), 64'(want.pad));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_depth = 0;
            peak_seen  = 0;
            acq_cnt    = '0;
            cont_cnt   = '0;
            nest_cnt   = '0;
            reent_cnt  = '0;
            uncont_cnt = '0;
            expected_tallies.delete();
            o_pending <= 0;
        end else begin
            // a result transfer always belongs to an older input, so pop first
            if (i_m_tvalid && i_m_tready) begin
                if (expected_tallies.size() == 0) begin
                    report_mismatch("result with nothing pending", i_m_tdata[63:0], 64'd0);
                end else begin
                    oldest_tally = expected_tallies.pop_front();
                    compare_tally(t_tally'(i_m_tdata), oldest_tally);
                end
                results_seen++;
            end
            if (i_s_tvalid && i_s_tready)
                expected_tallies.push_back(apply_lock_event(i_s_tuser, i_s_tdata));
            o_pending <= expected_tallies.size();
        end
    end

endmodule

### dv/lock_hold_stack_auditor_top_tb.sv
// Top of the lock hold stack auditor bench: clock, reset, event stimulus with
// idle/stall phases and a long output hold-off, plus the final verdict.
// Depends on lhsa_pkg, lock_hold_stack_auditor_top and the checker module.
`timescale 1ns / 1ps

module lock_hold_stack_auditor_top_tb;

    import lhsa_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int POOL_N      = 40;
    localparam int BURST_LEN   = 40;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 4000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [LOCK_ID_W-1:0] s_tdata = '0;   // [63:0] lock_id
    logic [OP_W-1:0]      s_tuser = '0;   // [2:0] operation
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [175:0]         m_tdata;        // counters, depths and flags, see dut

    int fail_count;
    int pending;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    logic [LOCK_ID_W-1:0] id_pool [POOL_N];

    lock_hold_stack_auditor_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    lock_hold_stack_auditor_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [LOCK_ID_W-1:0] id);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= id;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic refresh_pool();
        for (int k = 0; k < POOL_N; k++) begin
            // neighbors one bit apart stress the full-width compare
            if (k > 0 && $urandom_range(3) == 0)
                id_pool[k] = id_pool[k-1] ^ (64'd1 << $urandom_range(63));
            else
                id_pool[k] = {$urandom, $urandom};
        end
    endtask

    task automatic send_random(input int acq_pct, input int rel_pct);
        int                   r;
        logic [OP_W-1:0]      op;
        logic [LOCK_ID_W-1:0] id;
        r = $urandom_range(99);
        id = id_pool[$urandom_range(POOL_N-1)];
        if ($urandom_range(19) == 0)
            id = {$urandom, $urandom};
        if (r < acq_pct) begin
            op = OP_ACQUIRE;
        end else if (r < acq_pct + rel_pct) begin
            op = OP_RELEASE;
        end else begin
            r = $urandom_range(99);
            if (r < 40)
                op = OP_CONTENDED;
            else if (r < 80)
                op = OP_UNCONTENDED;
            else if (r < 88)
                op = OP_CLEAR;
            else if (r < 92)
                op = OP_SPARE_5;
            else if (r < 96)
                op = OP_SPARE_6;
            else
                op = OP_SPARE_7;
        end
        send_item(op, id);
    endtask

    task automatic send_burst();
        int mode;
        mode = $urandom_range(2);
        for (int n = 0; n < BURST_LEN; n++) begin
            case (mode)
                0: send_random(70, 15);   // mostly growing the stack
                1: send_random(15, 70);   // mostly draining
                default: send_random(40, 35);
            endcase
        end
    endtask

    initial begin
        logic [LOCK_ID_W-1:0] id_a;
        logic [LOCK_ID_W-1:0] id_b;
        logic [LOCK_ID_W-1:0] id_ones;
        id_a = {32{2'b01}};
        id_b = {32{2'b10}};
        id_ones = '1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty release, nesting, reentry, middle removal, spare codes, clear
        send_item(OP_RELEASE, '0);
        send_item(OP_ACQUIRE, '0);
        send_item(OP_ACQUIRE, id_ones);
        send_item(OP_ACQUIRE, id_a);
        send_item(OP_ACQUIRE, id_b);
        send_item(OP_ACQUIRE, '0);
        send_item(OP_ACQUIRE, id_b);
        send_item(OP_RELEASE, id_ones);
        send_item(OP_RELEASE, id_ones);
        send_item(OP_ACQUIRE, id_ones);
        send_item(OP_CONTENDED, id_a);
        send_item(OP_UNCONTENDED, id_b);
        send_item(OP_SPARE_5, id_ones);
        send_item(OP_SPARE_6, '0);
        send_item(OP_SPARE_7, id_a);
        send_item(OP_CLEAR, '0);
        send_item(OP_ACQUIRE, id_a);
        send_item(OP_RELEASE, '0);
        send_item(OP_RELEASE, id_ones);
        send_item(OP_RELEASE, id_a);
        send_item(OP_RELEASE, id_b);
        send_item(OP_ACQUIRE, 64'h8000_0000_0000_0001);
        send_item(OP_RELEASE, 64'h8000_0000_0000_0001);

        // fill past capacity so the full-stack acquire is hit early
        refresh_pool();
        for (int k = 0; k < 36; k++)
            send_item(OP_ACQUIRE, id_pool[k]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct = 48; sink_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct <= 48; end
                default: begin src_idle_pct = 20; sink_stall_pct <= 20; end
            endcase
            refresh_pool();
            for (int b = 0; b < 7; b++)
                send_burst();
        end

        // back-pressure: results held off while input keeps coming
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        for (int n = 0; n < BURST_LEN; n++)
            send_random(45, 35);

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
